/* rtl/linear_grid_binning_unit_defines.svh */
// Assertion macros used by the checker file glb_checker.sv.
`ifndef LINEAR_GRID_BINNING_UNIT_DEFINES_SVH
`define LINEAR_GRID_BINNING_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLB_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLB_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* rtl/glb_pkg.sv */
`timescale 1ns / 1ps
package glb_pkg;

	localparam int MAX_GRID_POINTS = 256;
	localparam int BIN_IDX_W = $clog2(MAX_GRID_POINTS);
	localparam int HALF_BINS = MAX_GRID_POINTS / 2;
	localparam int HALF_AW = BIN_IDX_W - 1;
	localparam int GP_W = $clog2(MAX_GRID_POINTS + 1);
	localparam int BIN_W = 48;
	localparam int WGT_W = 32;
	localparam int CMD_FIFO_DEPTH = 4;
	// three front stages, the command queue, the back latch and the result register
	localparam int READS_IN_FLIGHT_MAX = CMD_FIFO_DEPTH + 5;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [2:0] CFG_GRID_ORIGIN = 3'd0;
	localparam logic [2:0] CFG_INV_BIN_WIDTH = 3'd1;
	localparam logic [2:0] CFG_GRID_POINTS = 3'd2;
	localparam logic [2:0] CFG_LINEAR_MODE = 3'd3;
	localparam logic [2:0] CFG_TRUNCATE_ENDS = 3'd4;

	localparam logic signed [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
	localparam logic signed [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_CLR,
		CMD_ADD,
		CMD_RD
	} cmd_op_t;

	typedef struct packed {
		logic signed [31:0] grid_origin;
		logic [31:0]        inv_bin_width;
		logic [8:0]         grid_points;
		logic               linear_mode;
		logic               truncate_ends;
	} cfg_t;

	typedef struct packed {
		cmd_op_t                  op;
		logic [BIN_IDX_W-1:0]     idx;
		logic                     pair;
		logic                     zero;
		logic signed [WGT_W-1:0]  wa;
		logic signed [WGT_W-1:0]  wb;
	} cmd_t;

endpackage

/* rtl/glb_ram.sv */
`timescale 1ns / 1ps
module glb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/glb_cmd_fifo.sv */
`timescale 1ns / 1ps
module glb_cmd_fifo import glb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
	localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t             mem_q [CMD_FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(CMD_FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/glb_front.sv */
`timescale 1ns / 1ps
module glb_front import glb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic signed [31:0] sample_value,
	input  logic signed [31:0] sample_weight,
	input  logic [7:0]         read_index,
	output logic               q_push,
	output cmd_t               q_cmd,
	input  logic               q_full
);

	logic               adv;
	logic               accept;
	logic signed [32:0] diff;
	logic               d_pos;

	logic                     v_s1;
	logic [1:0]               mode_s1;
	logic [31:0]              dist_s1;
	logic signed [WGT_W-1:0]  w_s1;
	logic [BIN_IDX_W-1:0]     ridx_s1;
	logic                     roob_s1;

	logic                     v_s2;
	logic [1:0]               mode_s2;
	logic [63:0]              prod_s2;
	logic signed [WGT_W-1:0]  w_s2;
	logic [BIN_IDX_W-1:0]     ridx_s2;
	logic                     roob_s2;

	logic [63:0]              prod_c;
	logic [31:0]              li;
	logic [31:0]              frac;
	logic [GP_W-1:0]          m_pts;
	logic [31:0]              m_last;
	logic                     lo_end;
	logic                     hi_end;
	logic signed [64:0]       wf_c;
	logic                     emit_c;
	cmd_t                     cmd_c;

	logic                     v_s3;
	logic                     emit_s3;
	cmd_t                     cmd_s3;
	logic signed [64:0]       wf_s3;
	logic signed [WGT_W-1:0]  share;

	assign adv = !(v_s3 && emit_s3 && q_full);
	assign full = !adv;
	assign accept = push && adv;

	assign diff = 33'(sample_value) - 33'(cfg.grid_origin);
	assign d_pos = !diff[32] && (diff[31:0] != '0);

	// position in bins, Q32.32
	assign prod_c = dist_s1 * cfg.inv_bin_width;

	assign li = prod_s2[63:32];
	assign frac = prod_s2[31:0];
	assign wf_c = w_s2 * $signed({1'b0, frac});

	always_comb begin
		if (cfg.grid_points < 9'd3) begin
			m_pts = GP_W'(3);
		end else if (32'(cfg.grid_points) > 32'(MAX_GRID_POINTS)) begin
			m_pts = GP_W'(MAX_GRID_POINTS);
		end else begin
			m_pts = GP_W'(cfg.grid_points);
		end
	end

	assign m_last = 32'(m_pts) - 32'd1;
	assign lo_end = (li == '0);
	assign hi_end = (li >= m_last);

	always_comb begin
		emit_c = 1'b0;
		cmd_c.op = CMD_CLR;
		cmd_c.idx = '0;
		cmd_c.pair = 1'b0;
		cmd_c.zero = 1'b0;
		cmd_c.wa = w_s2;
		cmd_c.wb = '0;
		case (mode_s2)
			MODE_CLEAR: begin
				emit_c = 1'b1;
			end
			MODE_ADD: begin
				cmd_c.op = CMD_ADD;
				if (lo_end) begin
					emit_c = !cfg.truncate_ends;
				end else if (hi_end) begin
					emit_c = !cfg.truncate_ends;
					cmd_c.idx = cfg.linear_mode ? BIN_IDX_W'(m_last) :
						BIN_IDX_W'(m_last - 32'd1);
				end else begin
					emit_c = 1'b1;
					cmd_c.idx = BIN_IDX_W'(li);
					cmd_c.pair = cfg.linear_mode;
				end
			end
			MODE_READ: begin
				emit_c = 1'b1;
				cmd_c.op = CMD_RD;
				cmd_c.idx = ridx_s2;
				cmd_c.zero = roob_s2;
			end
			default: begin
				emit_c = 1'b0;
			end
		endcase
	end

	// floor(w * f / 2^32): the arithmetic shift rounds toward minus infinity
	assign share = wf_s3[63:32];

	always_comb begin
		q_cmd = cmd_s3;
		if (cmd_s3.pair) begin
			q_cmd.wa = cmd_s3.wa - share;
			q_cmd.wb = share;
		end
	end

	assign q_push = v_s3 && emit_s3 && !q_full;

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			dist_s1 <= d_pos ? diff[31:0] : '0;
			w_s1 <= sample_weight;
			ridx_s1 <= BIN_IDX_W'(read_index);
			roob_s1 <= (32'(read_index) >= 32'(MAX_GRID_POINTS));
			mode_s2 <= mode_s1;
			prod_s2 <= prod_c;
			w_s2 <= w_s1;
			ridx_s2 <= ridx_s1;
			roob_s2 <= roob_s1;
			cmd_s3 <= cmd_c;
			wf_s3 <= wf_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			emit_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			emit_s3 <= v_s2 && emit_c;
		end
	end

endmodule

/* rtl/glb_back.sv */
`timescale 1ns / 1ps
module glb_back import glb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    head,
	input  logic                    q_empty,
	output logic                    q_pop,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [BIN_W-1:0] bin_value
);

	typedef enum logic [2:0] {
		BK_IDLE = 3'b001,
		BK_WR   = 3'b010,
		BK_RD   = 3'b100
	} bk_state_t;

	bk_state_t              state_q;
	cmd_t                   cmd_q;
	logic [HALF_BINS-1:0]   vld0_q;
	logic [HALF_BINS-1:0]   vld1_q;
	logic                   vrd0_q;
	logic                   vrd1_q;
	logic                   out_valid_q;
	logic signed [BIN_W-1:0] out_q;

	logic [BIN_IDX_W-1:0]   head_nxt;
	logic [BIN_IDX_W-1:0]   cur_nxt;
	logic [HALF_AW-1:0]     raddr0;
	logic [HALF_AW-1:0]     raddr1;
	logic [HALF_AW-1:0]     waddr0;
	logic [HALF_AW-1:0]     waddr1;
	logic [BIN_W-1:0]       rd0;
	logic [BIN_W-1:0]       rd1;
	logic signed [BIN_W-1:0] old0;
	logic signed [BIN_W-1:0] old1;
	logic signed [WGT_W-1:0] w0;
	logic signed [WGT_W-1:0] w1;
	logic signed [BIN_W-1:0] new0;
	logic signed [BIN_W-1:0] new1;
	logic                   we0;
	logic                   we1;

	function automatic logic signed [BIN_W-1:0] sat_add(
		input logic signed [BIN_W-1:0] a,
		input logic signed [WGT_W-1:0] b
	);
		logic signed [BIN_W:0] s;
		s = {a[BIN_W-1], a} + {{(BIN_W - WGT_W + 1){b[WGT_W-1]}}, b};
		if (s[BIN_W] != s[BIN_W-1]) begin
			return s[BIN_W] ? BIN_MIN : BIN_MAX;
		end
		return s[BIN_W-1:0];
	endfunction

	// even bins live in bank 0, odd bins in bank 1
	assign head_nxt = head.idx + 1'b1;
	assign raddr0 = head.idx[0] ? head_nxt[BIN_IDX_W-1:1] : head.idx[BIN_IDX_W-1:1];
	assign raddr1 = head.idx[BIN_IDX_W-1:1];

	assign cur_nxt = cmd_q.idx + 1'b1;
	assign waddr0 = cmd_q.idx[0] ? cur_nxt[BIN_IDX_W-1:1] : cmd_q.idx[BIN_IDX_W-1:1];
	assign waddr1 = cmd_q.idx[BIN_IDX_W-1:1];

	assign w0 = cmd_q.idx[0] ? cmd_q.wb : cmd_q.wa;
	assign w1 = cmd_q.idx[0] ? cmd_q.wa : cmd_q.wb;
	assign we0 = (state_q == BK_WR) && (cmd_q.pair || !cmd_q.idx[0]);
	assign we1 = (state_q == BK_WR) && (cmd_q.pair || cmd_q.idx[0]);

	// a bin never written since the last clear reads as zero
	assign old0 = vrd0_q ? rd0 : '0;
	assign old1 = vrd1_q ? rd1 : '0;
	assign new0 = sat_add(old0, w0);
	assign new1 = sat_add(old1, w1);

	assign q_pop = (state_q == BK_IDLE) && !q_empty && (head.op != CMD_RD || !out_valid_q);

	assign empty = !out_valid_q;
	assign bin_value = out_q;

	glb_ram #(
		.WIDTH(BIN_W),
		.DEPTH(HALF_BINS)
	) u_bank0 (
		.clk  (clk),
		.we   (we0),
		.waddr(waddr0),
		.wdata(new0),
		.raddr(raddr0),
		.rdata(rd0)
	);

	glb_ram #(
		.WIDTH(BIN_W),
		.DEPTH(HALF_BINS)
	) u_bank1 (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr1),
		.wdata(new1),
		.raddr(raddr1),
		.rdata(rd1)
	);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= head;
		end
		if (state_q == BK_RD) begin
			if (cmd_q.zero) begin
				out_q <= '0;
			end else begin
				out_q <= cmd_q.idx[0] ? old1 : old0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			vld0_q <= '0;
			vld1_q <= '0;
			vrd0_q <= 1'b0;
			vrd1_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vrd0_q <= vld0_q[raddr0];
			vrd1_q <= vld1_q[raddr1];
			if (q_pop && head.op == CMD_CLR) begin
				vld0_q <= '0;
				vld1_q <= '0;
			end else begin
				if (we0) begin
					vld0_q[waddr0] <= 1'b1;
				end
				if (we1) begin
					vld1_q[waddr1] <= 1'b1;
				end
			end
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end else if (state_q == BK_RD) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						case (head.op)
							CMD_ADD: state_q <= BK_WR;
							CMD_RD:  state_q <= BK_RD;
							default: state_q <= BK_IDLE;
						endcase
					end
				end
				BK_WR: state_q <= BK_IDLE;
				BK_RD: state_q <= BK_IDLE;
				default: state_q <= BK_IDLE;
			endcase
		end
	end

endmodule

/* rtl/linear_grid_binning_unit.sv */
`timescale 1ns / 1ps
// channel   handshake          payload
// input     push / full        mode, sample_value, sample_weight, read_index
// result    empty / pop        bin_value
// config    cfg_we             cfg_index, cfg_data
//
// An item passes through the front stages (subtract, position multiply,
// weight-split multiply), then waits in a four-entry command queue.
// For an add or a read the back first reads the even and odd bin banks, then
// writes back the updated bin or bin pair or registers the read result; a
// clear is done at the pop. A new command is taken only once the last is done.
// Reset and clear mark every bin empty at once through per-bin valid bits.
// A read waits in the queue while an earlier result has not been popped.
module linear_grid_binning_unit import glb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic [1:0]              mode,
	input  logic signed [31:0]      sample_value,
	input  logic signed [31:0]      sample_weight,
	input  logic [7:0]              read_index,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [BIN_W-1:0] bin_value,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	cfg_t cfg_q;
	logic q_push;
	cmd_t q_wdata;
	logic q_full;
	logic q_pop;
	cmd_t q_rdata;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_origin <= '0;
			cfg_q.inv_bin_width <= 32'd65536;
			cfg_q.grid_points <= 9'd256;
			cfg_q.linear_mode <= 1'b1;
			cfg_q.truncate_ends <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_ORIGIN:   cfg_q.grid_origin <= cfg_data;
				CFG_INV_BIN_WIDTH: cfg_q.inv_bin_width <= cfg_data;
				CFG_GRID_POINTS:   cfg_q.grid_points <= cfg_data[8:0];
				CFG_LINEAR_MODE:   cfg_q.linear_mode <= cfg_data[0];
				CFG_TRUNCATE_ENDS: cfg_q.truncate_ends <= cfg_data[0];
				default: ;
			endcase
		end
	end

	glb_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.sample_value (sample_value),
		.sample_weight(sample_weight),
		.read_index   (read_index),
		.q_push       (q_push),
		.q_cmd        (q_wdata),
		.q_full       (q_full)
	);

	glb_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	glb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.bin_value(bin_value)
	);

endmodule

/* rtl/glb_checker.sv */
`timescale 1ns / 1ps
`include "linear_grid_binning_unit_defines.svh"
module glb_checker import glb_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    push,
	input logic                    full,
	input logic [1:0]              mode,
	input logic                    empty,
	input logic                    pop,
	input logic signed [BIN_W-1:0] bin_value
);

	localparam int PEND_W = $clog2(READS_IN_FLIGHT_MAX + 2);

	logic [PEND_W-1:0] pending_q;
	logic              rd_in;
	logic              rd_out;

	assign rd_in = push && !full && (mode == MODE_READ);
	assign rd_out = pop && !empty;

	// count read transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (rd_in && !rd_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (rd_out && !rd_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`GLB_ASSERT_SAME(a_no_spurious_result, clk, arst_n, pending_q == '0, empty, "result without a read")
	`GLB_ASSERT_SAME(a_reads_bounded, clk, arst_n, 1'b1, pending_q <= PEND_W'(READS_IN_FLIGHT_MAX), "too many reads in flight")
	`GLB_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop, !empty && $stable(bin_value), "stalled result changed")

endmodule

bind linear_grid_binning_unit glb_checker u_glb_checker (.*);

/* tb/sv/grid_bin_checker.sv */
`timescale 1ns / 1ps
module grid_bin_checker import glb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic [1:0]              mode,
	input  logic signed [31:0]      sample_value,
	input  logic signed [31:0]      sample_weight,
	input  logic [7:0]              read_index,
	input  logic                    empty,
	input  logic                    pop,
	input  logic signed [BIN_W-1:0] bin_value,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data,
	output int                      mismatch_count,
	output int                      results_pending
);

	localparam longint BIN_TOP = BIN_MAX;
	localparam longint BIN_BOTTOM = BIN_MIN;

	longint bin_totals [MAX_GRID_POINTS];
	logic signed [BIN_W-1:0] expected_reads [$];
	logic signed [BIN_W-1:0] expected_value;

	logic signed [31:0] origin_q;
	logic [31:0]        width_q;
	logic [8:0]         points_q;
	logic               linear_q;
	logic               truncate_q;

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic add_to_bin(input longint slot, input longint amount);
		longint total;
		if (slot < 0 || slot >= MAX_GRID_POINTS)
			return;
		total = bin_totals[slot] + amount;
		if (total > BIN_TOP)
			total = BIN_TOP;
		else if (total < BIN_BOTTOM)
			total = BIN_BOTTOM;
		bin_totals[slot] = total;
	endtask

	task automatic spread_sample(input logic signed [31:0] x, input logic signed [31:0] w);
		logic signed [32:0] offset;
		logic [63:0] position;
		longint slot;
		longint span;
		longint upper_share;
		offset = $signed({x[31], x}) - $signed({origin_q[31], origin_q});
		position = '0;
		if (offset > 0)
			position = {32'd0, offset[31:0]} * {32'd0, width_q};
		slot = longint'(position[63:32]);
		span = points_q;
		if (span < 3)
			span = 3;
		else if (span > MAX_GRID_POINTS)
			span = MAX_GRID_POINTS;

		if (slot == 0) begin
			if (!truncate_q)
				add_to_bin(0, w);
		end else if (slot >= span - 1) begin
			if (!truncate_q)
				add_to_bin(linear_q ? span - 1 : span - 2, w);
		end else if (linear_q) begin
			// upper neighbor takes floor(w * frac / 2^32), lower one keeps the rest
			upper_share = (longint'(w) * longint'({32'd0, position[31:0]})) >>> 32;
			add_to_bin(slot, longint'(w) - upper_share);
			add_to_bin(slot + 1, upper_share);
		end else begin
			add_to_bin(slot, w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (bin_totals[i])
				bin_totals[i] = 0;
			expected_reads.delete();
			origin_q = '0;
			width_q = 32'h0001_0000;
			points_q = 9'd256;
			linear_q = 1'b1;
			truncate_q = 1'b0;
			mismatch_count = 0;
			results_pending <= 0;
		end else begin
			// a result leaving this edge is older than a read arriving at it
			if (pop && !empty) begin
				if (expected_reads.size() == 0) begin
					report_mismatch($sformatf("bin_value %0d with no read outstanding",
						bin_value));
				end else begin
					expected_value = expected_reads.pop_front();
					if (bin_value !== expected_value)
						report_mismatch($sformatf("bin_value %0d, expected %0d",
							bin_value, expected_value));
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_GRID_ORIGIN:   origin_q = cfg_data;
					CFG_INV_BIN_WIDTH: width_q = cfg_data;
					CFG_GRID_POINTS:   points_q = cfg_data[8:0];
					CFG_LINEAR_MODE:   linear_q = cfg_data[0];
					CFG_TRUNCATE_ENDS: truncate_q = cfg_data[0];
					default: ;
				endcase
			end

			if (push && !full) begin
				case (mode)
					MODE_CLEAR: begin
						foreach (bin_totals[i])
							bin_totals[i] = 0;
					end
					MODE_ADD:  spread_sample(sample_value, sample_weight);
					MODE_READ: expected_reads.push_back(BIN_W'(bin_totals[read_index]));
					default: ;
				endcase
			end

			results_pending <= expected_reads.size();
		end
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import glb_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STEADY_PAIRS = 100;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    push = 1'b0;
	logic                    full;
	logic [1:0]              mode = MODE_CLEAR;
	logic signed [31:0]      sample_value = '0;
	logic signed [31:0]      sample_weight = '0;
	logic [7:0]              read_index = '0;
	logic                    empty;
	logic                    pop = 1'b0;
	logic signed [BIN_W-1:0] bin_value;
	logic                    cfg_we = 1'b0;
	logic [2:0]              cfg_index = CFG_GRID_ORIGIN;
	logic [31:0]             cfg_data = '0;

	int mismatch_count;
	int results_pending;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_off_request = 1'b0;
	int hold_left = 0;
	int unsigned cycle_count = 0;
	cfg_t active_grid;

	cfg_t fixed_grids [7] = '{
		'{32'shFFF6_0000, 32'h0002_0000, 9'd16,  1'b1, 1'b0},
		'{32'sh8000_0000, 32'hFFFF_FFFF, 9'd3,   1'b0, 1'b1},
		'{32'sh7FFF_FFFF, 32'h0000_0001, 9'd256, 1'b0, 1'b0},
		// zero inverse width and a size below the minimum
		'{32'sh0000_0000, 32'h0000_0000, 9'd0,   1'b1, 1'b0},
		'{32'shFF80_0000, 32'h0000_8000, 9'd511, 1'b1, 1'b1},
		'{32'sh0000_0000, 32'h0001_0000, 9'd2,   1'b0, 1'b0},
		'{32'sh0010_0000, 32'h0004_0000, 9'd1,   1'b1, 1'b1}
	};

	linear_grid_binning_unit uut (.*);

	grid_bin_checker binning_check (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("linear_grid_binning_unit verification failed");
			$finish;
		end
	end

	// result side: random stalls, an optional long hold-off, or steady popping
	always @(posedge clk) begin
		if (hold_off_request) begin
			hold_off_request = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (rx_steady) begin
			pop <= 1'b1;
		end else begin
			pop <= ($urandom_range(99) >= 17);
		end
	end

	task automatic send_item(input logic [1:0] op, input logic [31:0] pos,
			input logic [31:0] wgt, input logic [7:0] slot);
		if (!tx_steady) begin
			while ($urandom_range(99) < 17) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push <= 1'b1;
		mode <= op;
		sample_value <= pos;
		sample_weight <= wgt;
		read_index <= slot;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_quiet;
		push <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		// let trailing adds and clears leave the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_grid(input cfg_t setting);
		active_grid = setting;
		cfg_we <= 1'b1;
		cfg_index <= CFG_GRID_ORIGIN;
		cfg_data <= setting.grid_origin;
		@(posedge clk);
		cfg_index <= CFG_INV_BIN_WIDTH;
		cfg_data <= setting.inv_bin_width;
		@(posedge clk);
		cfg_index <= CFG_GRID_POINTS;
		cfg_data <= 32'(setting.grid_points);
		@(posedge clk);
		cfg_index <= CFG_LINEAR_MODE;
		cfg_data <= 32'(setting.linear_mode);
		@(posedge clk);
		cfg_index <= CFG_TRUNCATE_ENDS;
		cfg_data <= 32'(setting.truncate_ends);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int count);
		int unsigned span;
		int unsigned pick;
		int unsigned target_bin;
		logic [63:0] target;
		longint pos;
		logic [31:0] x;
		logic [31:0] w;
		logic [7:0] slot;
		span = active_grid.grid_points;
		if (span < 3)
			span = 3;
		else if (span > MAX_GRID_POINTS)
			span = MAX_GRID_POINTS;
		repeat (count) begin
			case ($urandom_range(9))
				0: w = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				1: w = int'($urandom_range(131072)) - 65536;
				default: w = $urandom();
			endcase

			// aim most positions at a chosen bin, with the ends and beyond well represented
			case ($urandom_range(9))
				0: target_bin = 0;
				1: target_bin = span - 2;
				2: target_bin = span - 1;
				3: target_bin = span;
				default: target_bin = $urandom_range(span - 2, 1);
			endcase
			target = {32'(target_bin), 32'($urandom())};
			if (active_grid.inv_bin_width == 0 || $urandom_range(9) == 0) begin
				x = $urandom();
			end else begin
				pos = longint'(active_grid.grid_origin)
					+ longint'(target / active_grid.inv_bin_width);
				x = (pos > POS_MAX || pos < POS_MIN) ? $urandom() : pos[31:0];
			end

			slot = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(span - 1));

			pick = $urandom_range(99);
			if (pick < 55)
				send_item(MODE_ADD, x, w, 8'($urandom()));
			else if (pick < 88)
				send_item(MODE_READ, $urandom(), $urandom(), slot);
			else if (pick < 93)
				send_item(MODE_ADD, $urandom(), w, 8'($urandom()));
			else if (pick < 97)
				send_item(MODE_UNUSED, $urandom(), $urandom(), 8'($urandom()));
			else
				send_item(MODE_CLEAR, $urandom(), $urandom(), 8'($urandom()));
		end
	endtask

	initial begin
		cfg_t setting;
		active_grid = '{32'sd0, 32'h0001_0000, 9'd256, 1'b1, 1'b0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset grid: unit width, 256 points, linear split, ends kept
		send_item(MODE_READ, 32'h0, 32'h0, 8'd0);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd255);
		send_item(MODE_ADD, 32'h0005_8000, 32'h0001_0000, 8'd0);
		send_item(MODE_ADD, 32'h0000_0000, 32'h7FFF_FFFF, 8'd0);
		send_item(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 8'd0);
		send_item(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
		send_item(MODE_ADD, 32'h00FF_0000, 32'hFFFF_0000, 8'd0);
		send_item(MODE_ADD, 32'h00FE_C000, 32'h8000_0000, 8'd0);
		send_item(MODE_ADD, 32'h0001_0000, 32'h0000_0003, 8'd0);
		send_item(MODE_ADD, 32'h0000_FFFF, 32'hFFFF_FFFB, 8'd0);
		send_item(MODE_UNUSED, 32'h0003_0000, 32'h0001_0000, 8'd3);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd0);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd1);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd2);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd3);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd5);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd6);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd254);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd255);
		send_item(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd5);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd255);

		// hold the result side so reads back up and the input stalls
		hold_off_request = 1'b1;
		random_traffic(60);
		wait_quiet();

		foreach (fixed_grids[i]) begin
			program_grid(fixed_grids[i]);
			random_traffic(130);
			wait_quiet();
		end

		// steady burst of extreme weights onto two bins, then step each back
		program_grid('{32'sd0, 32'h0001_0000, 9'd256, 1'b0, 1'b0});
		tx_steady = 1'b1;
		send_item(MODE_CLEAR, 32'h0, 32'h0, 8'd0);
		repeat (STEADY_PAIRS) begin
			send_item(MODE_ADD, 32'h000A_0000, 32'h7FFF_FFFF, 8'd0);
			send_item(MODE_ADD, 32'h0014_0000, 32'h8000_0000, 8'd0);
		end
		send_item(MODE_READ, 32'h0, 32'h0, 8'd10);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd20);
		send_item(MODE_ADD, 32'h000A_0000, 32'h8000_0000, 8'd0);
		send_item(MODE_ADD, 32'h0014_0000, 32'h7FFF_FFFF, 8'd0);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd10);
		send_item(MODE_READ, 32'h0, 32'h0, 8'd20);
		tx_steady = 1'b0;
		wait_quiet();

		for (int phase = 0; phase < 4; phase++) begin
			setting.grid_origin = $urandom();
			setting.inv_bin_width = $urandom_range(1)
				? $urandom_range(32'h0010_0000, 32'h0000_1000) : $urandom();
			setting.grid_points = ($urandom_range(3) == 0)
				? 9'($urandom_range(511)) : 9'($urandom_range(64, 3));
			setting.linear_mode = 1'($urandom_range(1));
			setting.truncate_ends = 1'($urandom_range(1));
			rx_steady = (phase == 1);
			program_grid(setting);
			random_traffic(160);
			wait_quiet();
		end
		rx_steady = 1'b0;

		if (mismatch_count == 0)
			$display("linear_grid_binning_unit verification clean");
		else
			$display("linear_grid_binning_unit verification failed");
		$finish;
	end

endmodule
